// File: sv/lr_pkg.sv
package lr_pkg;

    localparam int COORD_BITS   = 16;
    localparam int COLOR_BITS   = 32;
    // decision value and its two increments, with headroom for 2 * delta
    localparam int ERR_BITS     = COORD_BITS + 4;
    localparam int IN_RAW_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    typedef enum logic [1:0] {
        MODE_STEEP_UP   = 2'd0,
        MODE_STEEP_DOWN = 2'd1,
        MODE_FLAT_UP    = 2'd2,
        MODE_FLAT_DOWN  = 2'd3
    } t_mode;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    // classified item, endpoints already ordered so that x rises
    typedef struct packed {
        logic                    kind;
        t_coord                  ax;
        t_coord                  ay;
        t_coord                  bx;
        t_coord                  by;
        logic [COORD_BITS-1:0]   dx;
        logic [COORD_BITS-1:0]   dy;
        logic                    down;
        logic [COLOR_BITS-1:0]   color;
    } t_cmd;

endpackage

// File: sv/lr_front.sv
module lr_front (
    input  logic                              i_valid,
    input  logic [lr_pkg::IN_DATA_BITS-1:0]   i_data,
    input  logic                              i_kind,
    output logic                              o_push,
    output lr_pkg::t_cmd                      o_cmd
);

    localparam int C = lr_pkg::COORD_BITS;

    lr_pkg::t_coord      ax;
    lr_pkg::t_coord      ay;
    lr_pkg::t_coord      bx;
    lr_pkg::t_coord      by;
    logic                swap;
    logic signed [C:0]   xd_fwd;
    logic signed [C:0]   xd_rev;
    logic signed [C:0]   yd_fwd;
    logic signed [C:0]   yd_rev;
    logic signed [C:0]   yd_sel;
    logic signed [C:0]   yd_oth;

    always_comb begin
        ax = i_data[C-1:0];
        ay = i_data[2*C-1:C];
        bx = i_data[3*C-1:2*C];
        by = i_data[4*C-1:3*C];
        swap = bx < ax;

        // both orders in parallel, the compare only selects
        xd_fwd = {bx[C-1], bx} - {ax[C-1], ax};
        xd_rev = {ax[C-1], ax} - {bx[C-1], bx};
        yd_fwd = {by[C-1], by} - {ay[C-1], ay};
        yd_rev = {ay[C-1], ay} - {by[C-1], by};
        yd_sel = swap ? yd_rev : yd_fwd;
        yd_oth = swap ? yd_fwd : yd_rev;

        o_cmd.kind  = i_kind;
        o_cmd.ax    = swap ? bx : ax;
        o_cmd.ay    = swap ? by : ay;
        o_cmd.bx    = swap ? ax : bx;
        o_cmd.by    = swap ? ay : by;
        o_cmd.dx    = swap ? xd_rev[C-1:0] : xd_fwd[C-1:0];
        o_cmd.down  = yd_sel[C];
        o_cmd.dy    = yd_sel[C] ? yd_oth[C-1:0] : yd_sel[C-1:0];
        o_cmd.color = i_data[4*C+lr_pkg::COLOR_BITS-1:4*C];
        o_push      = i_valid;
    end

endmodule

// File: sv/lr_fifo.sv
module lr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lr_pkg::t_cmd  i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output lr_pkg::t_cmd  o_cmd
);

    lr_pkg::t_cmd r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         wr_en;
    logic         rd_en;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/lr_back.sv
module lr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  lr_pkg::t_cmd                        i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lr_pkg::COORD_BITS-1:0]       o_x,
    output logic [lr_pkg::COORD_BITS-1:0]       o_y,
    output logic [lr_pkg::COLOR_BITS-1:0]       o_color,
    output logic                                o_last
);

    localparam int C  = lr_pkg::COORD_BITS;
    localparam int EP = lr_pkg::ERR_BITS - C;

    logic                          r_busy;
    lr_pkg::t_mode                 r_mode;
    lr_pkg::t_coord                r_cur_x;
    lr_pkg::t_coord                r_cur_y;
    lr_pkg::t_coord                r_stop;
    lr_pkg::t_err                  r_err;
    lr_pkg::t_err                  r_step_minor;
    lr_pkg::t_err                  r_step_both;
    logic [lr_pkg::COLOR_BITS-1:0] r_color;
    logic                          r_out_valid;
    lr_pkg::t_coord                r_out_x;
    lr_pkg::t_coord                r_out_y;
    logic [lr_pkg::COLOR_BITS-1:0] r_out_color;
    logic                          r_out_last;

    lr_pkg::t_err   dx_e;
    lr_pkg::t_err   dy_e;
    logic           steep;
    lr_pkg::t_mode  s_mode;
    lr_pkg::t_coord s_x;
    lr_pkg::t_coord s_y;
    lr_pkg::t_coord s_stop;
    lr_pkg::t_err   s_err;
    lr_pkg::t_err   s_minor;
    lr_pkg::t_err   s_both;
    logic           s_last;
    logic           take;
    lr_pkg::t_coord n_x;
    lr_pkg::t_coord n_y;
    lr_pkg::t_err   n_err;
    logic           n_last;

    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_color = r_out_color;
    assign o_last  = r_out_last;

    // set up a new line
    always_comb begin
        dx_e  = {{EP{1'b0}}, i_cmd.dx};
        dy_e  = {{EP{1'b0}}, i_cmd.dy};
        steep = i_cmd.dy > i_cmd.dx;
        if (steep) begin
            s_mode  = i_cmd.down ? lr_pkg::MODE_STEEP_DOWN : lr_pkg::MODE_STEEP_UP;
            s_x     = i_cmd.ax;
            s_y     = i_cmd.ay;
            s_stop  = i_cmd.by;
            s_err   = (dx_e <<< 1) - dy_e;
            s_minor = dx_e <<< 1;
            s_both  = (dx_e - dy_e) <<< 1;
        end else begin
            s_mode  = i_cmd.down ? lr_pkg::MODE_FLAT_DOWN : lr_pkg::MODE_FLAT_UP;
            // falling shallow case walks back from the right endpoint
            s_x     = i_cmd.down ? i_cmd.bx : i_cmd.ax;
            s_y     = i_cmd.down ? i_cmd.by : i_cmd.ay;
            s_stop  = i_cmd.down ? i_cmd.ax : i_cmd.bx;
            s_err   = (dy_e <<< 1) - dx_e;
            s_minor = dy_e <<< 1;
            s_both  = (dy_e - dx_e) <<< 1;
        end
        // only a single point ends at its first pixel
        s_last = (i_cmd.dx == '0) && (i_cmd.dy == '0);
    end

    // one Bresenham step
    always_comb begin
        take  = !r_err[lr_pkg::ERR_BITS-1];
        n_err = r_err + (take ? r_step_both : r_step_minor);
        n_x   = r_cur_x;
        n_y   = r_cur_y;
        case (r_mode)
            lr_pkg::MODE_STEEP_UP: begin
                n_y = r_cur_y + C'(1);
                if (take) n_x = r_cur_x + C'(1);
            end
            lr_pkg::MODE_STEEP_DOWN: begin
                n_y = r_cur_y - C'(1);
                if (take) n_x = r_cur_x + C'(1);
            end
            lr_pkg::MODE_FLAT_UP: begin
                n_x = r_cur_x + C'(1);
                if (take) n_y = r_cur_y + C'(1);
            end
            default: begin
                n_x = r_cur_x - C'(1);
                if (take) n_y = r_cur_y + C'(1);
            end
        endcase
        if (r_mode == lr_pkg::MODE_STEEP_UP || r_mode == lr_pkg::MODE_STEEP_DOWN) begin
            n_last = n_y == r_stop;
        end else begin
            n_last = n_x == r_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_mode       <= lr_pkg::MODE_STEEP_UP;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_stop       <= '0;
            r_err        <= '0;
            r_step_minor <= '0;
            r_step_both  <= '0;
            r_color      <= '0;
            r_out_valid  <= 1'b0;
        end else if (o_pop) begin
            if (i_cmd.kind == lr_pkg::KIND_START) begin
                r_mode       <= s_mode;
                r_cur_x      <= s_x;
                r_cur_y      <= s_y;
                r_stop       <= s_stop;
                r_err        <= s_err;
                r_step_minor <= s_minor;
                r_step_both  <= s_both;
                r_color      <= i_cmd.color;
                r_busy       <= !s_last;
                r_out_valid  <= 1'b1;
            end else if (r_busy) begin
                r_cur_x      <= n_x;
                r_cur_y      <= n_y;
                r_err        <= n_err;
                r_busy       <= !n_last;
                r_out_valid  <= 1'b1;
            end else begin
                // next item with no line running: dropped
                r_out_valid  <= 1'b0;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.kind == lr_pkg::KIND_START) begin
                r_out_x     <= s_x;
                r_out_y     <= s_y;
                r_out_color <= i_cmd.color;
                r_out_last  <= s_last;
            end else begin
                r_out_x     <= n_x;
                r_out_y     <= n_y;
                r_out_color <= r_color;
                r_out_last  <= n_last;
            end
        end
    end

endmodule

// File: sv/line_rasterizer.sv
// Bresenham line rasterizer, one pixel per item.
// Input channel s_axis: tuser is the item kind (start or next); a start item
// carries both endpoints and the color in tdata, a next item's tdata is
// ignored. A start item gives the first pixel at once; each next item gives
// the following pixel. A next item with no line running gives no pixel.
// Output channel m_axis: tdata holds the pixel, tlast marks the final pixel.
// Endpoints are swapped as needed so that x rises; the falling shallow
// case walks from the right endpoint back to the left.
// An item passes the queue entry, then the back end's output register,
// before its pixel appears on m_axis.
// Throughput: one item per cycle while m_axis is ready; each step is one
// add and compare on the error term in the back end. A two-entry queue
// between the classifying front end and the stepping back end, plus the
// output register, keeps s_axis ready while a result waits, so a stall on
// m_axis fills the queue and only then drops o_s_axis_tready.
// Reset (synchronous, active low) empties the queue, clears the output
// valid and ends any running line.
module line_rasterizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [lr_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // kind
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [lr_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // last_pixel
    output logic                              o_m_axis_tlast
);

    logic                          push;
    logic                          fifo_ready;
    logic                          fifo_valid;
    logic                          pop;
    lr_pkg::t_cmd                  front_cmd;
    lr_pkg::t_cmd                  head_cmd;
    logic [lr_pkg::COORD_BITS-1:0] px;
    logic [lr_pkg::COORD_BITS-1:0] py;
    logic [lr_pkg::COLOR_BITS-1:0] pcolor;

    assign o_s_axis_tready = fifo_ready;
    assign o_m_axis_tdata  = lr_pkg::OUT_DATA_BITS'({pcolor, py, px});

    lr_front u_front (
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_kind  (i_s_axis_tuser),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    lr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (fifo_ready),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_cmd   (head_cmd)
    );

    lr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fifo_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_x     (px),
        .o_y     (py),
        .o_color (pcolor),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: tb/line_rasterizer_tb.sv
module line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1750;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [lr_pkg::IN_DATA_BITS-1:0]  t_in_data;
    typedef logic [lr_pkg::OUT_DATA_BITS-1:0] t_out_data;
    typedef logic [lr_pkg::COLOR_BITS-1:0]    t_color;

    typedef struct {
        lr_pkg::t_coord x;
        lr_pkg::t_coord y;
        t_color         color;
        logic           last;
    } t_pixel;

    // Mirrors the rasterizer walk and holds the pixels still owed by the block.
    class pixel_tracker;
        bit             busy;
        lr_pkg::t_mode  mode;
        lr_pkg::t_coord cur_x;
        lr_pkg::t_coord cur_y;
        lr_pkg::t_coord stop_coord;
        longint         err;
        longint         step_minor;
        longint         step_both;
        t_color         color;
        t_pixel         pending_pixels[$];
        int             mismatches;

        function new();
            busy = 0;
            mode = lr_pkg::MODE_STEEP_UP;
            cur_x = '0;
            cur_y = '0;
            stop_coord = '0;
            err = 0;
            step_minor = 0;
            step_both = 0;
            color = '0;
            mismatches = 0;
        endfunction

        function void note_item(logic kind, t_in_data data);
            lr_pkg::t_coord ax, ay, bx, by, tmp;
            longint dx, dy;
            bit     take;
            bit     last;
            t_pixel pix;
            if (kind == lr_pkg::KIND_START) begin
                ax = data[lr_pkg::COORD_BITS-1:0];
                ay = data[2*lr_pkg::COORD_BITS-1:lr_pkg::COORD_BITS];
                bx = data[3*lr_pkg::COORD_BITS-1:2*lr_pkg::COORD_BITS];
                by = data[4*lr_pkg::COORD_BITS-1:3*lr_pkg::COORD_BITS];
                color = data[4*lr_pkg::COORD_BITS+lr_pkg::COLOR_BITS-1:4*lr_pkg::COORD_BITS];
                if (bx < ax) begin
                    tmp = ax; ax = bx; bx = tmp;
                    tmp = ay; ay = by; by = tmp;
                end
                dx = longint'(bx) - longint'(ax);
                if (by >= ay) begin
                    dy = longint'(by) - longint'(ay);
                    mode = (dy > dx) ? lr_pkg::MODE_STEEP_UP : lr_pkg::MODE_FLAT_UP;
                end else begin
                    dy = longint'(ay) - longint'(by);
                    mode = (dy > dx) ? lr_pkg::MODE_STEEP_DOWN : lr_pkg::MODE_FLAT_DOWN;
                end
                if (dy > dx) begin
                    cur_x = ax;
                    cur_y = ay;
                    stop_coord = by;
                    err = 2 * dx - dy;
                    step_minor = 2 * dx;
                    step_both = 2 * dx - 2 * dy;
                end else begin
                    // falling shallow lines walk from the right endpoint leftward
                    cur_x = (mode == lr_pkg::MODE_FLAT_DOWN) ? bx : ax;
                    cur_y = (mode == lr_pkg::MODE_FLAT_DOWN) ? by : ay;
                    stop_coord = (mode == lr_pkg::MODE_FLAT_DOWN) ? ax : bx;
                    err = 2 * dy - dx;
                    step_minor = 2 * dy;
                    step_both = 2 * dy - 2 * dx;
                end
            end else begin
                if (!busy) return;
                take = (err >= 0);
                err += take ? step_both : step_minor;
                case (mode)
                    lr_pkg::MODE_STEEP_UP: begin
                        cur_y = cur_y + 16'sd1;
                        if (take) cur_x = cur_x + 16'sd1;
                    end
                    lr_pkg::MODE_STEEP_DOWN: begin
                        cur_y = cur_y - 16'sd1;
                        if (take) cur_x = cur_x + 16'sd1;
                    end
                    lr_pkg::MODE_FLAT_UP: begin
                        cur_x = cur_x + 16'sd1;
                        if (take) cur_y = cur_y + 16'sd1;
                    end
                    default: begin
                        cur_x = cur_x - 16'sd1;
                        if (take) cur_y = cur_y + 16'sd1;
                    end
                endcase
            end
            if (mode == lr_pkg::MODE_STEEP_UP || mode == lr_pkg::MODE_STEEP_DOWN)
                last = (cur_y == stop_coord);
            else
                last = (cur_x == stop_coord);
            busy = !last;
            pix.x = cur_x;
            pix.y = cur_y;
            pix.color = color;
            pix.last = last;
            pending_pixels.push_back(pix);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_pixel(t_out_data data, logic last);
            t_pixel want;
            lr_pkg::t_coord got_x, got_y;
            t_color got_color;
            got_x = data[lr_pkg::COORD_BITS-1:0];
            got_y = data[2*lr_pkg::COORD_BITS-1:lr_pkg::COORD_BITS];
            got_color = data[2*lr_pkg::COORD_BITS+lr_pkg::COLOR_BITS-1:2*lr_pkg::COORD_BITS];
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel (%0d,%0d)", got_x, got_y));
                return;
            end
            want = pending_pixels.pop_front();
            if (got_x !== want.x)
                report($sformatf("pixel_x got %0d want %0d", got_x, want.x));
            if (got_y !== want.y)
                report($sformatf("pixel_y got %0d want %0d", got_y, want.y));
            if (got_color !== want.color)
                report($sformatf("pixel_color got %h want %h", got_color, want.color));
            if (last !== want.last)
                report($sformatf("last_pixel got %b want %b", last, want.last));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      s_tvalid = 1'b0;
    logic      s_tready;
    t_in_data  s_tdata = '0;
    logic      s_tuser = lr_pkg::KIND_NEXT;
    logic      m_tvalid;
    logic      m_tready = 1'b0;
    t_out_data m_tdata;
    logic      m_tlast;

    pixel_tracker sb = new();
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  quiet = 0;

    line_rasterizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
    end

    // output backpressure: short stalls between ready stretches
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    function automatic t_in_data pack_line(lr_pkg::t_coord sx, lr_pkg::t_coord sy,
                                           lr_pkg::t_coord ex, lr_pkg::t_coord ey,
                                           t_color c);
        return t_in_data'({c, ey, ex, sy, sx});
    endfunction

    function automatic int line_span(lr_pkg::t_coord sx, lr_pkg::t_coord sy,
                                     lr_pkg::t_coord ex, lr_pkg::t_coord ey);
        int dx, dy;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic kind, t_in_data data);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(kind, data);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_next();
        send_item(lr_pkg::KIND_NEXT, {$urandom, $urandom, $urandom});
    endtask

    task automatic draw_line(lr_pkg::t_coord sx, lr_pkg::t_coord sy,
                             lr_pkg::t_coord ex, lr_pkg::t_coord ey,
                             t_color c, int steps);
        send_item(lr_pkg::KIND_START, pack_line(sx, sy, ex, ey, c));
        repeat (steps) send_next();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        lr_pkg::t_coord sx, sy, ex, ey;
        int     span, steps, pick;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_next();                                        // idle, no pixel
        draw_line(16'sd5, -16'sd3, 16'sd5, -16'sd3, 32'h0, 0);         // single point
        draw_line(16'sd0, 16'sd0, 16'sd1, 16'sd2, 32'h1234_5678, 2);   // steep rising
        draw_line(16'sd0, 16'sd0, 16'sd1, -16'sd2, 32'h8765_4321, 2);  // steep falling
        draw_line(16'sd0, 16'sd0, 16'sd2, 16'sd1, 32'hA5A5_5A5A, 2);   // shallow rising
        draw_line(16'sd0, 16'sd0, 16'sd2, -16'sd1, 32'h5A5A_A5A5, 2);  // shallow falling
        draw_line(16'sd10, 16'sd10, 16'sd8, 16'sd8, 32'hFFFF_FFFF, 2); // swapped, equal extents
        draw_line(16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, 32'hFFFF_FFFF, 1);
        // restart while a line runs
        draw_line(16'sd32767, 16'sh8000, 16'sd32767, 16'sd32767, 32'h0, 1);
        draw_line(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 32'hDEAD_BEEF, 0);
        send_next();
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1;
            if (items_sent > 800 && items_sent < 820) wait_drained();
            pick = $urandom_range(0, 99);
            sx = lr_pkg::t_coord'($urandom);
            sy = lr_pkg::t_coord'($urandom);
            if (pick < 92 && pick >= 85) begin
                ex = lr_pkg::t_coord'($urandom);
                ey = lr_pkg::t_coord'($urandom);
            end else begin
                ex = sx + lr_pkg::t_coord'($urandom_range(0, 40)) - 16'sd20;
                ey = sy + lr_pkg::t_coord'($urandom_range(0, 40)) - 16'sd20;
                if ($urandom_range(0, 9) == 0) ex = sx;
                if ($urandom_range(0, 9) == 0) ey = sy;
            end
            span = line_span(sx, sy, ex, ey);
            if (pick < 70) begin
                // full walk, sometimes with trailing nexts that hit idle
                steps = (span > 64) ? $urandom_range(1, 30) : span;
                if ($urandom_range(0, 4) == 0) steps += $urandom_range(1, 2);
                draw_line(sx, sy, ex, ey, $urandom, steps);
            end else if (pick < 92) begin
                // walk cut short by the next start
                steps = (span > 40) ? $urandom_range(0, 40) :
                        (span > 0 ? $urandom_range(0, span - 1) : 0);
                draw_line(sx, sy, ex, ey, $urandom, steps);
            end else begin
                repeat ($urandom_range(1, 3)) send_next();
            end
        end
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
